// File: hw/rtl/sseg_pkg.sv
package sseg_pkg;

  localparam int unsigned NumW  = 14;
  localparam int unsigned BcdW  = 16;
  localparam int unsigned CntW  = $clog2(NumW + 1);
  localparam int unsigned IdxW  = 3;

  localparam logic [7:0] CmdData = 8'h40;
  localparam logic [7:0] CmdAddr = 8'hC0;
  localparam logic [7:0] CmdCtrl = 8'h80;
  localparam logic [7:0] DotMask = 8'h80;

  localparam logic ReqNumber = 1'b0;

  localparam logic [IdxW-1:0] ItemData = 3'd0;
  localparam logic [IdxW-1:0] ItemAddr = 3'd1;
  localparam logic [IdxW-1:0] ItemSeg0 = 3'd2;
  localparam logic [IdxW-1:0] ItemSeg3 = 3'd5;
  localparam logic [IdxW-1:0] ItemCtrl = 3'd6;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] bin;
  } bcd_req_t;

  typedef struct packed {
    logic            done;
    logic [BcdW-1:0] bcd;
  } bcd_rsp_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// File: hw/rtl/sseg_if.sv
interface sseg_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [13:0] number;
  logic [7:0]  dots_in;
  logic [7:0]  seg_byte0;
  logic [7:0]  seg_byte1;
  logic [7:0]  seg_byte2;
  logic [7:0]  seg_byte3;
  logic [1:0]  start_pos;

  modport source (
    output valid, req_type, number, dots_in, seg_byte0, seg_byte1, seg_byte2,
           seg_byte3, start_pos,
    input  ready
  );
  modport sink (
    input  valid, req_type, number, dots_in, seg_byte0, seg_byte1, seg_byte2,
           seg_byte3, start_pos,
    output ready
  );
endinterface

interface sseg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       start_before;
  logic       stop_after;
  logic       last;

  modport source (
    output valid, out_byte, start_before, stop_after, last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, start_before, stop_after, last,
    output ready
  );
endinterface

// File: hw/rtl/seven_segment_display_frame_writer_top.sv
// Frame writer for a four-digit seven-segment display driver.
// in_ch (valid/ready) takes one update request per item; out_ch (valid/ready)
// returns seven items per request: data command, address command, four
// segment bytes ORed with the stored dot mask, and the display control byte.
// start_before/stop_after mark the link conditions, last flags the seventh.
// cfg_we_i/cfg_wdata_i write the 4-bit brightness nibble; write only while idle.
// Number mode: the value is converted to decimal by a bit-serial shift-add-3
// converter, one binary bit per cycle, then the seven bytes follow one per
// cycle while the receiver is ready. Raw mode skips the converter and goes
// straight to emitting the seven bytes.
// One request is in flight at a time; in_ch.ready is high only between
// requests. The output register holds an item until taken, so a stalled
// receiver simply pauses the sequence without loss.
// Reset clears the brightness and the stored dot mask and empties the output.
module seven_segment_display_frame_writer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  sseg_in_if.sink    in_ch,
  sseg_out_if.source out_ch
);
  import sseg_pkg::*;

  logic [3:0] brightness_q;
  bcd_req_t   bcd_req;
  bcd_rsp_t   bcd_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= '0;
    end else if (cfg_we_i) begin
      brightness_q <= cfg_wdata_i;
    end
  end

  sseg_bcd u_bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (bcd_req),
    .rsp_o  (bcd_rsp)
  );

  sseg_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .brightness_i (brightness_q),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .bcd_req_o    (bcd_req),
    .bcd_rsp_i    (bcd_rsp)
  );

endmodule

// File: hw/rtl/sseg_bcd.sv
module sseg_bcd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sseg_pkg::bcd_req_t req_i,
  output sseg_pkg::bcd_rsp_t rsp_o
);
  import sseg_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] bin_q, bin_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [BcdW-1:0] adj;

  // add-3 correction per digit, then shift in one binary bit; the carry out
  // of the thousands digit is dropped, which keeps the value modulo 10000
  always_comb begin
    for (int k = 0; k < BcdW / 4; k++) begin
      adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
                                                 : bcd_q[4*k +: 4];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      bin_d  = req_i.bin;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[NumW-1]};
      bin_d = {bin_q[NumW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.bcd  = bcd_q;

endmodule

// File: hw/rtl/sseg_frame.sv
module sseg_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3:0]         brightness_i,
  sseg_in_if.sink            in_ch,
  sseg_out_if.source         out_ch,
  output sseg_pkg::bcd_req_t bcd_req_o,
  input  sseg_pkg::bcd_rsp_t bcd_rsp_i
);
  import sseg_pkg::*;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [3:0][7:0] seg_q, seg_d;
  logic [1:0]      addr_q, addr_d;
  logic [7:0]      dots_q, dots_d;
  logic            ovalid_q, ovalid_d;
  logic [7:0]      obyte_q, obyte_d;
  logic            ostart_q, ostart_d;
  logic            ostop_q, ostop_d;
  logic            olast_q, olast_d;
  logic            load;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    seg_d    = seg_q;
    addr_d   = addr_q;
    dots_d   = dots_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    ostart_d = ostart_q;
    ostop_d  = ostop_q;
    olast_d  = olast_q;
    in_ch.ready     = 1'b0;
    bcd_req_o.start = 1'b0;
    bcd_req_o.bin   = in_ch.number;
    load = !ovalid_q || out_ch.ready;

    if (out_ch.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        in_ch.ready = 1'b1;
        idx_d = ItemData;
        if (in_ch.valid) begin
          if (in_ch.req_type == ReqNumber) begin
            bcd_req_o.start = 1'b1;
            addr_d  = 2'd0;
            dots_d  = in_ch.dots_in & DotMask;
            state_d = StConv;
          end else begin
            seg_d   = {in_ch.seg_byte3, in_ch.seg_byte2, in_ch.seg_byte1, in_ch.seg_byte0};
            addr_d  = in_ch.start_pos;
            state_d = StEmit;
          end
        end
      end
      StConv: begin
        if (bcd_rsp_i.done) begin
          for (int k = 0; k < 4; k++) begin
            seg_d[k] = seg_of(bcd_rsp_i.bcd[4*(3-k) +: 4]);
          end
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (load) begin
          ovalid_d = 1'b1;
          idx_d    = idx_q + IdxW'(1);
          ostart_d = 1'b0;
          ostop_d  = 1'b0;
          olast_d  = 1'b0;
          case (idx_q) inside
            ItemData: begin
              obyte_d  = CmdData;
              ostart_d = 1'b1;
              ostop_d  = 1'b1;
            end
            ItemAddr: begin
              obyte_d  = CmdAddr | {6'd0, addr_q};
              ostart_d = 1'b1;
            end
            [ItemSeg0:ItemSeg3]: begin
              obyte_d = seg_q[0] | dots_q;
              ostop_d = (idx_q == ItemSeg3);
              seg_d   = {8'd0, seg_q[3:1]};
            end
            default: begin
              obyte_d  = CmdCtrl | {4'd0, brightness_i};
              ostart_d = 1'b1;
              ostop_d  = 1'b1;
              olast_d  = 1'b1;
              state_d  = StIdle;
            end
          endcase
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= ItemData;
      dots_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      dots_q   <= dots_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q    <= seg_d;
    addr_q   <= addr_d;
    obyte_q  <= obyte_d;
    ostart_q <= ostart_d;
    ostop_q  <= ostop_d;
    olast_q  <= olast_d;
  end

  assign out_ch.valid        = ovalid_q;
  assign out_ch.out_byte     = obyte_q;
  assign out_ch.start_before = ostart_q;
  assign out_ch.stop_after   = ostop_q;
  assign out_ch.last         = olast_q;

endmodule

// File: test/tb_seven_segment_display_frame_writer_top.sv
module tb_seven_segment_display_frame_writer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sseg_pkg::*;

  typedef struct packed {
    logic        req_type;
    logic [13:0] number;
    logic [7:0]  dots_in;
    logic [7:0]  seg0;
    logic [7:0]  seg1;
    logic [7:0]  seg2;
    logic [7:0]  seg3;
    logic [1:0]  start_pos;
  } update_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       start_b;
    logic       stop_a;
    logic       is_last;
  } link_t;

  localparam logic ReqRaw = ~ReqNumber;
  localparam logic [7:0] DigitSeg [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;

  sseg_in_if  in_ch ();
  sseg_out_if out_ch ();

  seven_segment_display_frame_writer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  update_t    update_q [$];
  link_t      link_q [$];
  link_t      got_l;
  link_t      want_l;
  logic [3:0] bright_cfg;
  logic [7:0] dots_store;
  logic       in_taken;
  int         src_idle;
  int         snk_idle;
  int         fail_cnt;
  int         n_number;
  int         n_raw;
  int         n_bytes;

  initial begin
    clk_i = 1'b0;
  end
  always #5 clk_i = ~clk_i;

  function automatic void predict_update(update_t u);
    logic [13:0] n;
    logic [7:0]  segs [4];
    logic [7:0]  addr;
    int          k;
    if (u.req_type == ReqNumber) begin
      n = 14'(u.number % 14'd10000);
      for (k = 3; k >= 0; k--) begin
        segs[k] = DigitSeg[n % 14'd10];
        n = n / 14'd10;
      end
      dots_store = u.dots_in & DotMask;
      addr = 8'h00;
      n_number++;
    end else begin
      segs[0] = u.seg0;
      segs[1] = u.seg1;
      segs[2] = u.seg2;
      segs[3] = u.seg3;
      addr = {6'b0, u.start_pos};
      n_raw++;
    end
    link_q.push_back('{CmdData, 1'b1, 1'b1, 1'b0});
    link_q.push_back('{8'(CmdAddr + addr), 1'b1, 1'b0, 1'b0});
    for (k = 0; k < 4; k++) begin
      link_q.push_back('{segs[k] | dots_store, 1'b0, k == 3, 1'b0});
    end
    link_q.push_back('{8'(CmdCtrl + {4'b0, bright_cfg}), 1'b1, 1'b1, 1'b1});
  endfunction

  function automatic void add_update(logic rt, logic [13:0] num, logic [7:0] d,
                                     logic [7:0] s0, logic [7:0] s1, logic [7:0] s2,
                                     logic [7:0] s3, logic [1:0] sp);
    update_q.push_back('{rt, num, d, s0, s1, s2, s3, sp});
  endfunction

  function automatic void add_random();
    update_t u;
    u.req_type  = 1'($urandom_range(1));
    u.number    = ($urandom_range(4) == 0) ? 14'($urandom_range(16383))
                                           : 14'($urandom_range(9999));
    u.dots_in   = 8'($urandom);
    u.seg0      = 8'($urandom);
    u.seg1      = 8'($urandom);
    u.seg2      = 8'($urandom);
    u.seg3      = 8'($urandom);
    u.start_pos = 2'($urandom);
    update_q.push_back(u);
  endfunction

  // negedge: drive request items and receiver ready
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
      if (!(in_ch.valid && !in_taken)) begin
        in_taken = 1'b0;
        if (update_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          in_ch.valid     <= 1'b1;
          in_ch.req_type  <= update_q[0].req_type;
          in_ch.number    <= update_q[0].number;
          in_ch.dots_in   <= update_q[0].dots_in;
          in_ch.seg_byte0 <= update_q[0].seg0;
          in_ch.seg_byte1 <= update_q[0].seg1;
          in_ch.seg_byte2 <= update_q[0].seg2;
          in_ch.seg_byte3 <= update_q[0].seg3;
          in_ch.start_pos <= update_q[0].start_pos;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // posedge: accept requests, check link items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready && !in_taken) begin
        predict_update(update_q.pop_front());
        in_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got_l = '{out_ch.out_byte, out_ch.start_before, out_ch.stop_after, out_ch.last};
        n_bytes++;
        if (link_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("ERROR: unexpected link item byte %h start %b stop %b last %b",
                     got_l.octet, got_l.start_b, got_l.stop_a, got_l.is_last);
          end
        end else begin
          want_l = link_q.pop_front();
          if (got_l !== want_l) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("ERROR: link item %0d expected byte %h start %b stop %b last %b",
                       n_bytes, want_l.octet, want_l.start_b, want_l.stop_a,
                       want_l.is_last);
              $display("       got byte %h start %b stop %b last %b",
                       got_l.octet, got_l.start_b, got_l.stop_a, got_l.is_last);
            end
          end
        end
      end
    end
  end

  task automatic drain();
    do @(negedge clk_i);
    while (update_q.size() > 0 || link_q.size() > 0 || in_ch.valid);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_brightness(logic [3:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = val;
    bright_cfg  = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 4'h0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = 1'b0;
    in_ch.number    = '0;
    in_ch.dots_in   = '0;
    in_ch.seg_byte0 = '0;
    in_ch.seg_byte1 = '0;
    in_ch.seg_byte2 = '0;
    in_ch.seg_byte3 = '0;
    in_ch.start_pos = '0;
    out_ch.ready    = 1'b0;
    in_taken        = 1'b0;
    bright_cfg      = 4'h0;
    dots_store      = 8'h00;
    fail_cnt        = 0;
    n_number        = 0;
    n_raw           = 0;
    n_bytes         = 0;
    src_idle        = 34;
    snk_idle        = 81;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, brightness at reset value
    add_update(ReqRaw,    14'd0,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
    add_update(ReqRaw,    14'd0,     8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3);
    add_update(ReqNumber, 14'd0,     8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3);
    add_update(ReqNumber, 14'd9999,  8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
    add_update(ReqRaw,    14'd16383, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2'd1);
    add_update(ReqNumber, 14'd1234,  8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 2'd2);
    add_update(ReqRaw,    14'd0,     8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 2'd2);
    add_update(ReqNumber, 14'd5678,  8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
    add_update(ReqRaw,    14'd0,     8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 2'd3);
    add_update(ReqNumber, 14'd16383, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
    add_update(ReqNumber, 14'd10000, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
    add_update(ReqNumber, 14'd12345, 8'h01, 8'hAA, 8'h55, 8'hAA, 8'h55, 2'd1);
    add_update(ReqNumber, 14'd9876,  8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 2'd3);
    add_update(ReqRaw,    14'd9999,  8'h80, 8'h01, 8'h02, 8'h04, 8'h08, 2'd1);
    add_update(ReqNumber, 14'd4050,  8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
    add_update(ReqRaw,    14'd0,     8'h00, 8'h10, 8'h20, 8'h40, 8'h00, 2'd0);
    drain();

    write_brightness(4'hF);
    repeat (90) add_random();
    drain();

    src_idle = 81;
    snk_idle = 34;
    write_brightness(4'h0);
    repeat (90) add_random();
    drain();

    src_idle = 0;
    snk_idle = 0;
    write_brightness(4'($urandom));
    repeat (45) add_random();
    drain();
    write_brightness(4'($urandom));
    repeat (45) add_random();
    drain();

    if (link_q.size() > 0) fail_cnt++;
    $display("Covered %0d update requests (%0d number, %0d raw), %0d link bytes checked,",
             n_number + n_raw, n_number, n_raw, n_bytes);
    $display("brightness 0, 15 and random levels, with sender and receiver stalls.");
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
